/* rtl/core/mrf_pkg.sv */
// Shared types, constants and the byte-wide CRC-16 step for the request framer.
// No dependencies; every other file in rtl/core imports this package.
package mrf_pkg;

    localparam int LEN_W   = 9;   // frame index and payload length width
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W   = 2;
    localparam int CNT_W   = 3;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] FC_MULTI_COILS = 8'd15;
    localparam logic [7:0] FC_MULTI_REGS  = 8'd16;

    localparam logic [LEN_W-1:0] DEFAULT_PAYLOAD    = 9'd6;
    localparam logic [LEN_W-1:0] MULTI_BASE_PAYLOAD = 9'd7;
    localparam logic [LEN_W-1:0] FC_INDEX           = 9'd1;
    localparam logic [LEN_W-1:0] COUNT_INDEX        = 9'd6;

    // Number of result items pushed for one processed item
    localparam logic [1:0] PUSH_NONE    = 2'd0;
    localparam logic [1:0] PUSH_PAYLOAD = 2'd1;
    localparam logic [1:0] PUSH_WITH_CRC = 2'd3;

    typedef struct packed {
        logic [1:0]  cnt;        // PUSH_NONE, PUSH_PAYLOAD or PUSH_WITH_CRC
        logic [7:0]  data_byte;  // payload byte
        logic [15:0] crc;        // CRC after this byte, valid with PUSH_WITH_CRC
    } mrf_push_t;

    typedef struct packed {
        logic       last;
        logic [7:0] tx_byte;
    } mrf_entry_t;

    // Reflected CRC-16, one byte, eight shift steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/mrf_frame_ctrl.sv */
// Frame tracking for the request framer: byte index, length decode, running CRC.
// Depends on mrf_pkg.
module mrf_frame_ctrl #(
    parameter int MAX_FRAME = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_valid,
    input  logic [7:0]         item_byte,
    input  logic               item_first,
    output mrf_pkg::mrf_push_t push
);
    import mrf_pkg::*;

    localparam logic [LEN_W:0] PayloadCap = (LEN_W+1)'(MAX_FRAME - 2);
    localparam logic [LEN_W-1:0] MultiFirstLen =
        (MAX_FRAME - 2 < 7) ? LEN_W'(MAX_FRAME - 2) : MULTI_BASE_PAYLOAD;

    logic [LEN_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      crc_value_reg, crc_value_next;
    logic             multi_write_reg, multi_write_next;
    logic [LEN_W-1:0] payload_length_reg, payload_length_next;
    logic             frame_done_reg, frame_done_next;

    logic [LEN_W-1:0] idx;
    logic [15:0]      crc_in;
    logic [15:0]      crc_new;
    logic             mw;
    logic [LEN_W-1:0] len;
    logic [LEN_W:0]   multi_sum;
    logic [LEN_W:0]   idx_plus;

    assign multi_sum = {{(LEN_W-7){1'b0}}, item_byte} + {1'b0, MULTI_BASE_PAYLOAD};
    assign idx_plus  = {1'b0, idx} + (LEN_W+1)'(1);
    assign crc_new   = crc16_byte(crc_in, item_byte);

    always_comb begin
        // Restart on a first byte, otherwise continue from the stored frame
        idx    = item_first ? '0 : byte_index_reg;
        crc_in = item_first ? CRC_INIT : crc_value_reg;
        mw     = item_first ? 1'b0 : multi_write_reg;
        len    = item_first ? DEFAULT_PAYLOAD : payload_length_reg;

        if (idx == FC_INDEX &&
            (item_byte == FC_MULTI_COILS || item_byte == FC_MULTI_REGS)) begin
            mw  = 1'b1;
            len = MultiFirstLen;
        end
        if (idx == COUNT_INDEX && mw) begin
            len = (multi_sum > PayloadCap) ? PayloadCap[LEN_W-1:0]
                                           : multi_sum[LEN_W-1:0];
        end

        byte_index_next     = byte_index_reg;
        crc_value_next      = crc_value_reg;
        multi_write_next    = multi_write_reg;
        payload_length_next = payload_length_reg;
        frame_done_next     = frame_done_reg;
        push.cnt            = PUSH_NONE;
        push.data_byte      = item_byte;
        push.crc            = crc_new;

        if (item_valid && (item_first || !frame_done_reg)) begin
            multi_write_next    = mw;
            payload_length_next = len;
            if (idx >= len) begin
                // Clamp forbids this byte: close the frame without a CRC
                byte_index_next = idx;
                crc_value_next  = crc_in;
                frame_done_next = 1'b1;
            end else begin
                byte_index_next = idx_plus[LEN_W-1:0];
                crc_value_next  = crc_new;
                if (idx_plus >= {1'b0, len}) begin
                    push.cnt        = PUSH_WITH_CRC;
                    frame_done_next = 1'b1;
                end else begin
                    push.cnt        = PUSH_PAYLOAD;
                    frame_done_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg     <= '0;
            crc_value_reg      <= CRC_INIT;
            multi_write_reg    <= 1'b0;
            payload_length_reg <= DEFAULT_PAYLOAD;
            frame_done_reg     <= 1'b1;
        end else begin
            byte_index_reg     <= byte_index_next;
            crc_value_reg      <= crc_value_next;
            multi_write_reg    <= multi_write_next;
            payload_length_reg <= payload_length_next;
            frame_done_reg     <= frame_done_next;
        end
    end

endmodule

/* rtl/core/mrf_out_fifo.sv */
// Four-entry queue: takes up to three items a cycle, emits one on m_tready.
// Depends on mrf_pkg.
module mrf_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  mrf_pkg::mrf_push_t push,
    output logic               room,      // space for a full three-item push
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] tx_byte
    output logic               m_tlast
);
    import mrf_pkg::*;

    mrf_entry_t       mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    logic [PTR_W-1:0] wr1, wr2;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = mem_reg[rd_ptr_reg].tx_byte;
    assign m_tlast  = mem_reg[rd_ptr_reg].last;
    assign room     = (count_reg <= CNT_W'(FIFO_DEPTH - 3));
    assign wr1      = wr_ptr_reg + PTR_W'(1);
    assign wr2      = wr_ptr_reg + PTR_W'(2);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    // Payload entries need no reset
    always_ff @(posedge aclk) begin
        if (push.cnt != PUSH_NONE) begin
            mem_reg[wr_ptr_reg] <= '{last: 1'b0, tx_byte: push.data_byte};
        end
        if (push.cnt == PUSH_WITH_CRC) begin
            mem_reg[wr1] <= '{last: 1'b0, tx_byte: push.crc[7:0]};
            mem_reg[wr2] <= '{last: 1'b1, tx_byte: push.crc[15:8]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/modbus_rtu_request_framer.sv */
// Top level of the Modbus RTU request framer: input register, frame control, result queue.
// Depends on mrf_pkg, mrf_frame_ctrl and mrf_out_fifo.
//
// Takes a Modbus RTU request one byte per item, s_tuser high on the address
// byte, and emits the payload bytes followed by the CRC-16 (reflected 0xA001,
// seed 0xFFFF), low byte first, m_tlast on the high CRC byte. The frame is six
// payload bytes unless the function code is 15 or 16, in which case it is
// seven plus the byte count in byte 6, capped at MAX_FRAME - 2 payload bytes.
// Bytes beyond the frame, or before any first byte, are dropped; a first byte
// always restarts framing. An accepted byte is held in the input register and
// then written into the result queue, from which it is emitted. A payload item
// is taken every cycle while the sink keeps up; the item that ends a frame
// queues three results, and input holds until the four-entry result queue
// again has room for three.
module modbus_rtu_request_framer #(
    parameter int MAX_FRAME = 256   // 8 .. 264
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tuser,     // [0] first
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] tx_byte
    output logic       m_tlast
);
    import mrf_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       room;
    logic       advance;
    logic       s_accept;
    mrf_push_t  push;

    // Advance the held item once the queue can take its worst case
    assign advance  = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the item; payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    mrf_frame_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item_byte  (in_byte_reg),
        .item_first (in_first_reg),
        .push       (push)
    );

    mrf_out_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
